@@ hdl/fatdp_pkg.sv @@
// ----------------------------------------------------------------------------
// fatdp_pkg
// Shared types and constants for the FAT directory entry parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fatdp_pkg;

  localparam int unsigned EntryLen   = 32;
  localparam int unsigned PosW       = $clog2(EntryLen);
  localparam logic [7:0]  LfnAttr    = 8'h0F;
  localparam logic [11:0] BaseYear   = 12'd1980;
  localparam logic [4:0]  LfnMax     = 5'd31;
  localparam logic [15:0] IndexMax   = 16'hFFFF;
  localparam logic [15:0] IndexFirst = 16'd1;

  localparam int unsigned OutFieldW  = 197;
  localparam int unsigned OutDataW   = ((OutFieldW + 7) / 8) * 8;

  // Raw bytes of one entry, byte k at index k.
  typedef logic [EntryLen-1:0][7:0] entry_bytes_t;

  // Packed from the lowest bit up: short_name first, long_name_parts last.
  typedef struct packed {
    logic [4:0]  long_name_parts;
    logic [15:0] entry_number;
    logic [31:0] file_size;
    logic [15:0] first_cluster;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [7:0]  attributes;
    logic [23:0] extension;
    logic [63:0] short_name;
  } dir_result_t;

endpackage

`default_nettype wire

@@ hdl/fat_dir_entry_parser_top.sv @@
// ----------------------------------------------------------------------------
// fat_dir_entry_parser_top
// Groups a FAT directory byte stream into 32-byte entries and reports each
// short-name entry with its decoded fields.
//
// Input channel: one directory byte per transaction in in_tdata; in_tuser
// marks the first byte of a new directory, clears position and end flag
// and sets index to 1. Every 32nd byte closes an entry. Long-name entries
// (attribute 0x0F) are counted; an entry with first byte zero ends the
// directory and later bytes are dropped until the next in_tuser.
// Output channel: one transaction per reported entry, in the cycle after the
// byte that closes it, held in a single output register.
// Throughput: one byte per cycle. in_tready is high while the output
// register is empty or being taken, so a stall on out_tready holds off
// input only while a result is waiting.
// Reset: synchronous, active low; clears position, long-name count, end
// flag and output valid, and sets the running index to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_dir_entry_parser_top
  import fatdp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] dir_byte
  input  logic                in_tuser,   // [0] start_of_dir
  output logic                out_tvalid,
  input  logic                out_tready,
  // [63:0] short_name, [87:64] extension, [95:88] attributes,
  // [107:96] year, [111:108] month, [116:112] day, [121:117] hour,
  // [127:122] minute, [143:128] first_cluster, [175:144] file_size,
  // [191:176] entry_number, [196:192] long_name_parts, rest zero
  output logic [OutDataW-1:0] out_tdata
);

  logic [PosW-1:0]          pos_r, pos_nxt;
  logic [4:0]               lfn_r, lfn_nxt;
  logic                     end_r, end_nxt;
  logic [15:0]              idx_r, idx_nxt;
  logic [EntryLen-2:0][7:0] shift_r, shift_nxt;
  logic                     out_valid_r, out_valid_nxt;
  dir_result_t              out_data_r;

  logic                     in_acc;
  logic [PosW-1:0]          pos_eff;
  logic                     end_eff;
  logic [15:0]              idx_eff;
  logic                     closing;
  logic                     is_lfn;
  logic                     is_end;
  logic                     emit;
  entry_bytes_t             entry;
  dir_result_t              result;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign pos_eff = in_tuser ? '0 : pos_r;
  assign end_eff = in_tuser ? 1'b0 : end_r;
  assign idx_eff = in_tuser ? IndexFirst : idx_r;

  // Oldest shifted byte is entry byte 0; the incoming byte is the last one.
  always_comb begin
    for (int k = 0; k < EntryLen - 1; k++) begin
      entry[k] = shift_r[EntryLen-2-k];
    end
    entry[EntryLen-1] = in_tdata;
  end

  assign closing = !end_eff && (pos_eff == PosW'(EntryLen - 1));
  assign is_lfn  = entry[11] == LfnAttr;
  assign is_end  = entry[0] == 8'd0;
  assign emit    = in_acc && closing && !is_end && !is_lfn;

  fatdp_entry_decode u_decode (
    .entry           (entry),
    .entry_number    (idx_eff),
    .long_name_parts (lfn_r),
    .result          (result)
  );

  always_comb begin
    pos_nxt       = pos_r;
    lfn_nxt       = lfn_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    shift_nxt     = shift_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_acc) begin
      pos_nxt = pos_eff;
      end_nxt = end_eff;
      idx_nxt = idx_eff;
      if (!end_eff) begin
        shift_nxt = {shift_r[EntryLen-3:0], in_tdata};
        if (closing) begin
          pos_nxt = '0;
          if (is_lfn && lfn_r < LfnMax) begin
            lfn_nxt = lfn_r + 5'd1;
          end
          if (is_end) begin
            end_nxt = 1'b1;
          end else if (!is_lfn) begin
            lfn_nxt = '0;
            if (idx_eff < IndexMax) begin
              idx_nxt = idx_eff + 16'd1;
            end
          end
        end else begin
          pos_nxt = pos_eff + PosW'(1);
        end
      end
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      lfn_r       <= '0;
      end_r       <= 1'b0;
      idx_r       <= IndexFirst;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      lfn_r       <= lfn_nxt;
      end_r       <= end_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW - OutFieldW)'(0), out_data_r};

  a_end_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    end_r |-> pos_r == '0)
    else $error("end flag set with nonzero byte position");

  a_idx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 16'd0)
    else $error("running index reached zero");

  a_valid_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r == $past(emit))
    else $error("output valid does not match emitted entry");

  a_out_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.entry_number != 16'd0)
    else $error("result carries entry number zero");

endmodule

`default_nettype wire

@@ hdl/fatdp_entry_decode.sv @@
// ----------------------------------------------------------------------------
// fatdp_entry_decode
// Splits one 32-byte short-name entry into its result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fatdp_entry_decode
  import fatdp_pkg::*;
(
  input  entry_bytes_t entry,
  input  logic [15:0]  entry_number,
  input  logic [4:0]   long_name_parts,
  output dir_result_t  result
);

  always_comb begin
    result.short_name      = {entry[0], entry[1], entry[2], entry[3],
                              entry[4], entry[5], entry[6], entry[7]};
    result.extension       = {entry[8], entry[9], entry[10]};
    result.attributes      = entry[11];
    result.year            = {5'd0, entry[25][7:1]} + BaseYear;
    result.month           = {entry[25][0], entry[24][7:5]};
    result.day             = entry[24][4:0];
    result.hour            = entry[23][7:3];
    result.minute          = {entry[23][2:0], entry[22][7:5]};
    result.first_cluster   = {entry[27], entry[26]};
    result.file_size       = {entry[31], entry[30], entry[29], entry[28]};
    result.entry_number    = entry_number;
    result.long_name_parts = long_name_parts;
  end

endmodule

`default_nettype wire

@@ sim/tb_fat_dir_entry_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_dir_entry_parser_top
// Streams FAT directory bytes into the parser and checks every reported
// entry field by field against a cycle-free model of the entry decoder.
// A directed part covers field extremes, long-name counting, both kinds
// of directory end, ignored bytes and restarts. Random directories then
// run under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_fat_dir_entry_parser_top;
  import fatdp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 720;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned BusyPct     = 82;
  localparam int unsigned BothPct     = 28;

  localparam logic [7:0] AttrFolder  = 8'h10;
  localparam logic [7:0] AttrLabel   = 8'h08;
  localparam logic [7:0] AttrArchive = 8'h20;
  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] LfnFirst    = 8'h41;

  typedef enum logic [1:0] {
    IdleNone, IdleSender, IdleReceiver, IdleBoth
  } idle_mode_e;

  typedef enum logic [2:0] {
    KindFile, KindLfn, KindDeleted, KindLabel, KindFolder, KindEnd, KindLfnEnd
  } entry_kind_e;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } dir_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;   // [7:0] dir_byte
  logic                in_tuser = 1'b0;    // [0] start_of_dir
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [63:0] short_name ... [196:192] long_name_parts, rest zero
  logic [OutDataW-1:0] out_tdata;

  fat_dir_entry_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  dir_byte_t   dir_bytes_q[$];
  dir_result_t expected_entries[$];
  idle_mode_e  idle_mode = IdleNone;
  bit          byte_accepted = 1'b0;

  // decoder model state
  logic [PosW-1:0] entry_pos = '0;
  entry_bytes_t    entry_buf = '0;
  logic [4:0]      lfn_count = '0;
  bit              dir_ended = 1'b0;
  logic [15:0]     next_number = IndexFirst;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned entries_checked = 0;
  int unsigned dirs_started = 0;
  int unsigned lfn_seen = 0;

  task automatic parse_dir_byte(input logic [7:0] b, input logic start);
    dir_result_t r;
    if (start) begin
      entry_pos   = '0;
      dir_ended   = 1'b0;
      next_number = IndexFirst;
      dirs_started++;
    end
    if (dir_ended) return;
    entry_buf[entry_pos] = b;
    if (entry_pos < EntryLen - 1) begin
      entry_pos++;
      return;
    end
    entry_pos = '0;
    if (entry_buf[11] == LfnAttr) begin
      lfn_seen++;
      if (lfn_count < LfnMax) lfn_count++;
    end
    if (entry_buf[0] == 8'h00) begin
      dir_ended = 1'b1;
      return;
    end
    if (entry_buf[11] == LfnAttr) return;
    r.short_name      = {entry_buf[0], entry_buf[1], entry_buf[2], entry_buf[3],
                         entry_buf[4], entry_buf[5], entry_buf[6], entry_buf[7]};
    r.extension       = {entry_buf[8], entry_buf[9], entry_buf[10]};
    r.attributes      = entry_buf[11];
    r.year            = BaseYear + {5'd0, entry_buf[25][7:1]};
    r.month           = {entry_buf[25][0], entry_buf[24][7:5]};
    r.day             = entry_buf[24][4:0];
    r.hour            = entry_buf[23][7:3];
    r.minute          = {entry_buf[23][2:0], entry_buf[22][7:5]};
    r.first_cluster   = {entry_buf[27], entry_buf[26]};
    r.file_size       = {entry_buf[31], entry_buf[30], entry_buf[29], entry_buf[28]};
    r.entry_number    = next_number;
    r.long_name_parts = lfn_count;
    expected_entries.push_back(r);
    if (next_number < IndexMax) next_number++;
    lfn_count = '0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  function automatic bit stall_now(input bit sender);
    if (idle_mode == IdleBoth) return $urandom_range(0, 99) < BothPct;
    if (sender && idle_mode == IdleSender) return $urandom_range(0, 99) < BusyPct;
    if (!sender && idle_mode == IdleReceiver) return $urandom_range(0, 99) < BusyPct;
    return 1'b0;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!in_tvalid || byte_accepted) begin
      if (rst_n && dir_bytes_q.size() != 0 && !stall_now(1'b1)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= dir_bytes_q[0].data;
        in_tuser  <= dir_bytes_q[0].start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    byte_accepted = 1'b0;
    out_tready <= !stall_now(1'b0);
  end

  // monitor
  always @(posedge clk) begin
    dir_byte_t   head;
    dir_result_t want;
    dir_result_t got;
    cycles++;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        head = dir_bytes_q.pop_front();
        parse_dir_byte(head.data, head.start);
        byte_accepted = 1'b1;
        bytes_taken++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[OutFieldW-1:0];
        if (expected_entries.size() == 0) begin
          errors++;
          $display("%0t: unexpected entry: expected none, actual %0h", $time, out_tdata);
        end else begin
          want = expected_entries.pop_front();
          entries_checked++;
          check_field("short_name", want.short_name, got.short_name);
          check_field("extension", want.extension, got.extension);
          check_field("attributes", want.attributes, got.attributes);
          check_field("year", want.year, got.year);
          check_field("month", want.month, got.month);
          check_field("day", want.day, got.day);
          check_field("hour", want.hour, got.hour);
          check_field("minute", want.minute, got.minute);
          check_field("first_cluster", want.first_cluster, got.first_cluster);
          check_field("file_size", want.file_size, got.file_size);
          check_field("entry_number", want.entry_number, got.entry_number);
          check_field("long_name_parts", want.long_name_parts, got.long_name_parts);
          check_field("padding", '0, out_tdata[OutDataW-1:OutFieldW]);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d entries still expected", $time, expected_entries.size());
      $display("tb_fat_dir_entry_parser_top failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    dir_byte_t t;
    t.start = start;
    t.data  = b;
    dir_bytes_q.push_back(t);
  endtask

  task automatic push_entry(input entry_bytes_t e, input logic start);
    for (int k = 0; k < EntryLen; k++) push_byte(e[k], start && k == 0);
  endtask

  task automatic push_noise(input int unsigned n);
    for (int k = 0; k < n; k++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic entry_bytes_t fill_entry(input logic [7:0] first,
                                              input logic [7:0] fill,
                                              input logic [7:0] attr);
    entry_bytes_t e;
    for (int k = 0; k < EntryLen; k++) e[k] = fill;
    e[0]  = first;
    e[11] = attr;
    return e;
  endfunction

  function automatic entry_bytes_t make_entry(input entry_kind_e kind);
    entry_bytes_t e;
    for (int k = 0; k < EntryLen; k++) e[k] = 8'($urandom_range(0, 255));
    if (e[0] == 8'h00) e[0] = LfnFirst;
    if (e[11] == LfnAttr) e[11] = AttrArchive;
    case (kind)
      KindLfn:     e[11] = LfnAttr;
      KindDeleted: e[0]  = DeletedMark;
      KindLabel:   e[11] = AttrLabel;
      KindFolder:  e[11] = AttrFolder;
      KindEnd:     e[0]  = 8'h00;
      KindLfnEnd: begin
        e[0]  = 8'h00;
        e[11] = LfnAttr;
      end
      default: ;
    endcase
    return e;
  endfunction

  task automatic add_random_dirs(input int unsigned n_bytes);
    int unsigned added;
    int unsigned pick;
    int unsigned cut;
    int unsigned n_entries;
    int unsigned n_noise;
    entry_kind_e kind;
    bit          first;
    bit          stop;
    added = 0;
    while (added < n_bytes) begin
      n_entries = $urandom_range(1, 10);
      first     = 1'b1;
      stop      = 1'b0;
      for (int i = 0; i < n_entries && !stop && added < n_bytes; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // partial entry, abandoned by the next directory start
          cut = $urandom_range(1, EntryLen - 1);
          for (int k = 0; k < cut; k++) begin
            push_byte(8'($urandom_range(0, 255)), first && k == 0);
          end
          added += cut;
          stop = 1'b1;
        end else begin
          kind = pick < 55 ? KindFile :
                 pick < 75 ? KindLfn :
                 pick < 80 ? KindDeleted :
                 pick < 84 ? KindLabel :
                 pick < 89 ? KindFolder :
                 pick < 95 ? KindEnd : KindLfnEnd;
          push_entry(make_entry(kind), first);
          added += EntryLen;
          if (kind == KindEnd || kind == KindLfnEnd) begin
            n_noise = $urandom_range(0, 40);
            push_noise(n_noise);
            added += n_noise;
            stop = 1'b1;
          end
        end
        first = 1'b0;
      end
    end
  endtask

  task automatic wait_drained();
    while (dir_bytes_q.size() != 0 || expected_entries.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    push_entry(fill_entry(8'hFF, 8'hFF, 8'hFF), 1'b1);
    push_entry(fill_entry(8'h01, 8'h00, 8'h00), 1'b0);
    push_entry(make_entry(KindDeleted), 1'b0);
    push_entry(make_entry(KindLabel), 1'b0);
    push_entry(make_entry(KindFolder), 1'b0);
    push_entry(make_entry(KindLfn), 1'b0);
    push_entry(make_entry(KindLfn), 1'b0);
    push_entry(make_entry(KindFile), 1'b0);
    push_entry(make_entry(KindLfn), 1'b0);
    push_noise(10);
    push_entry(make_entry(KindFile), 1'b1);
    push_entry(make_entry(KindLfnEnd), 1'b0);
    push_noise(16);
    push_entry(make_entry(KindFile), 1'b1);
    push_entry(make_entry(KindEnd), 1'b0);
    push_noise(8);
    push_entry(fill_entry(8'hFF, 8'h00, 8'h00), 1'b1);
    push_entry(fill_entry(8'h80, 8'hFF, AttrArchive), 1'b0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_e'(p);
      add_random_dirs(RandomBytes / 4);
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Ran %0d directory bytes over %0d directory starts under four idle mixes;",
             bytes_taken, dirs_started);
    $display("checked %0d reported entries, %0d long-name parts counted, %0d errors.",
             entries_checked, lfn_seen, errors);
    if (errors == 0 && expected_entries.size() == 0) begin
      $display("tb_fat_dir_entry_parser_top passed");
    end else begin
      $display("tb_fat_dir_entry_parser_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fatdp_pkg.sv
hdl/fatdp_entry_decode.sv
hdl/fat_dir_entry_parser_top.sv
sim/tb_fat_dir_entry_parser_top.sv
